[rtl/pipd_pkg.sv]
package pipd_pkg;

   localparam int ENTRIES_DEFAULT = 8;
   localparam int LEVELS_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int NUMBER_W = 16;
   localparam int ARG_W = 32;
   localparam int INDEX_W = 3;
   localparam int PRIO_W = 4;
   localparam int COUNT_W = 4;
   localparam int IDS_W = 128;
   localparam int PRIOS_W = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic OP_RAISE = 1'b0;
   localparam logic OP_RUN = 1'b1;

   localparam logic KIND_RAISE = 1'b0;
   localparam logic KIND_RUN = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_IDS_LOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_IDS_HIGH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_PRIORITIES = 2'd3;

   typedef enum logic [2:0] {
      STATUS_ACCEPTED   = 3'd0,
      STATUS_DROPPED    = 3'd1,
      STATUS_UNKNOWN    = 3'd2,
      STATUS_DISPATCHED = 3'd3,
      STATUS_NONE       = 3'd4
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  entries_in_use;
      logic [IDS_W-1:0]    irq_ids;
      logic [PRIOS_W-1:0]  priorities;
   } csr_type;

   typedef struct packed {
      logic                opcode;
      logic [NUMBER_W-1:0] irq_number;
      logic [ARG_W-1:0]    argument;
   } req_item_type;

   typedef struct packed {
      logic          valid;
      req_item_type  item;
   } queue_head_type;

   typedef struct packed {
      logic               reply_kind;
      status_type         status;
      logic [INDEX_W-1:0] entry_index;
      logic [PRIO_W-1:0]  entry_priority;
      logic [ARG_W-1:0]   saved_argument;
      logic               last_result;
   } rsp_item_type;

endpackage

[rtl/pipd_queue.sv]
module pipd_queue #(
   parameter int DEPTH = pipd_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pipd_pkg::req_item_type  push_item,
   output logic                    ready,
   input  logic                    pop,
   output pipd_pkg::queue_head_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pipd_pkg::req_item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign ready = (count_ff != CW'(DEPTH));
   assign do_push = push && ready;
   assign do_pop = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/pipd_back.sv]
module pipd_back #(
   parameter int ENTRIES = pipd_pkg::ENTRIES_DEFAULT,
   parameter int PRIORITY_LEVELS = pipd_pkg::LEVELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pipd_pkg::csr_type        csr,
   input  pipd_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   output pipd_pkg::rsp_item_type   rsp_item,
   input  logic                     rsp_ready
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IW = pipd_pkg::INDEX_W;
   localparam int PW = pipd_pkg::PRIO_W;
   localparam int NW = pipd_pkg::NUMBER_W;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [ENTRIES-1:0]      pending_ff, pending_in;
   logic [ENTRIES-1:0]      mask_ff, mask_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pipd_pkg::rsp_item_type  rsp_ff, rsp_in;
   logic [pipd_pkg::ARG_W-1:0] args_ff [ENTRIES];

   logic                    arg_we;
   logic [AW-1:0]           arg_addr;
   logic                    out_free;
   logic [pipd_pkg::COUNT_W-1:0] used_n;
   logic [ENTRIES-1:0]      used_mask;
   logic [PW-1:0]           prio_c [ENTRIES];
   logic                    hit;
   logic [IW-1:0]           hit_idx;
   logic [PRIORITY_LEVELS-1:0] levels;
   logic [PW-1:0]           best_p;
   logic [IW-1:0]           chosen;
   logic [ENTRIES-1:0]      same_level;
   logic [ENTRIES-1:0]      mask_rest;
   logic [ENTRIES-1:0]      snapshot;
   logic [PW-1:0]           raw_p;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   // Table lookup and priority selection over the entries in use.
   always_comb begin
      used_n = (csr.entries_in_use > pipd_pkg::COUNT_W'(ENTRIES)) ?
               pipd_pkg::COUNT_W'(ENTRIES) : csr.entries_in_use;
      for (int k = 0; k < ENTRIES; k++) begin
         used_mask[k] = (pipd_pkg::COUNT_W'(k) < used_n);
         raw_p = csr.priorities[PW*k +: PW];
         prio_c[k] = (raw_p >= PW'(PRIORITY_LEVELS - 1)) ? PW'(PRIORITY_LEVELS - 1) : raw_p;
      end

      // The first matching entry wins, so scan from the top down.
      hit = 1'b0;
      hit_idx = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (used_mask[k] && csr.irq_ids[NW*k +: NW] == head.item.irq_number) begin
            hit = 1'b1;
            hit_idx = IW'(k);
         end
      end

      levels = '0;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
         for (int k = 0; k < ENTRIES; k++) begin
            if (mask_ff[k] && prio_c[k] == PW'(l)) begin
               levels[l] = 1'b1;
            end
         end
      end
      best_p = '0;
      for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
         if (levels[l]) begin
            best_p = PW'(l);
         end
      end

      // Among entries sharing the level the highest index wins; the rest are dropped.
      chosen = '0;
      same_level = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         if (mask_ff[k] && prio_c[k] == best_p) begin
            chosen = IW'(k);
            same_level[k] = 1'b1;
         end
      end
      mask_rest = mask_ff & ~same_level;
      snapshot = pending_ff & used_mask;
   end

   always_comb begin
      state_in = state_ff;
      pending_in = pending_ff;
      mask_in = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      pop = 1'b0;
      arg_we = 1'b0;
      arg_addr = hit_idx[AW-1:0];

      case (state_ff)
         BK_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.entry_index = '0;
               rsp_in.entry_priority = '0;
               rsp_in.saved_argument = '0;
               rsp_in.last_result = 1'b1;
               if (head.item.opcode == pipd_pkg::OP_RAISE) begin
                  rsp_in.reply_kind = pipd_pkg::KIND_RAISE;
                  if (hit) begin
                     rsp_in.entry_index = hit_idx;
                     if (pending_ff[hit_idx[AW-1:0]]) begin
                        rsp_in.status = pipd_pkg::STATUS_DROPPED;
                     end else begin
                        rsp_in.status = pipd_pkg::STATUS_ACCEPTED;
                        pending_in[hit_idx[AW-1:0]] = 1'b1;
                        arg_we = 1'b1;
                     end
                  end else begin
                     rsp_in.status = pipd_pkg::STATUS_UNKNOWN;
                  end
               end else begin
                  pending_in = '0;
                  if (snapshot == '0) begin
                     rsp_in.reply_kind = pipd_pkg::KIND_RUN;
                     rsp_in.status = pipd_pkg::STATUS_NONE;
                  end else begin
                     rsp_valid_in = rsp_valid_ff && !rsp_ready;
                     rsp_in = rsp_ff;
                     mask_in = snapshot;
                     state_in = BK_RUN;
                  end
               end
            end
         end
         BK_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.reply_kind = pipd_pkg::KIND_RUN;
               rsp_in.status = pipd_pkg::STATUS_DISPATCHED;
               rsp_in.entry_index = chosen;
               rsp_in.entry_priority = best_p;
               rsp_in.saved_argument = args_ff[chosen[AW-1:0]];
               rsp_in.last_result = (mask_rest == '0);
               mask_in = mask_rest;
               if (mask_rest == '0) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         pending_ff <= '0;
         mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pending_ff <= pending_in;
         mask_ff <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (arg_we) begin
         args_ff[arg_addr] <= head.item.argument;
      end
   end

endmodule

[rtl/pending_irq_priority_dispatcher.sv]
// Pending interrupt dispatcher with a table of up to ENTRIES entries.
// Configuration: csr_we writes csr_wdata into register csr_index (0 entries in
// use, 1 and 2 the 16-bit interrupt numbers, 3 the 4-bit priorities); write only
// while no item is in flight.
// Request channel (req_*): tuser selects raise (0) or run (1); a raise marks the
// first matching entry pending and keeps its argument, unless already pending.
// Response channel (rsp_*): a raise gives one item; a run gives one item per
// dispatched entry in ascending priority value, or one "none pending" item, with
// tlast on the final one. An accepted request is registered in the queue; the
// engine takes it and registers a raise reply, or the reply to a run with nothing
// pending, in the output register. A run first captures the pending set, then the
// selection loop dispatches one entry per cycle while the output register is free,
// taking no new request until the last dispatch. A two-item queue sits between
// input and engine, so requests are still taken while a result waits in the output
// register. When rsp_tready is low with a result waiting, the result register
// holds, the engine stops, and req_tready drops once the queue is full. Reset
// clears the configuration, the pending marks, the queue and the output valid bit.
module pending_irq_priority_dispatcher #(
   parameter int ENTRIES = pipd_pkg::ENTRIES_DEFAULT,
   parameter int PRIORITY_LEVELS = pipd_pkg::LEVELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pipd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pipd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pipd_pkg::REQ_DATA_W-1:0]     req_tdata,  // irq_number, argument
   input  logic                                req_tuser,  // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status, entry_index, entry_priority, saved_argument, zero fill
   output logic [pipd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,  // reply_kind
   output logic                                rsp_tlast
);

   logic [pipd_pkg::COUNT_W-1:0] entries_in_use_ff;
   logic [pipd_pkg::CSR_DATA_W-1:0] ids_low_ff;
   logic [pipd_pkg::CSR_DATA_W-1:0] ids_high_ff;
   logic [pipd_pkg::PRIOS_W-1:0] priorities_ff;

   pipd_pkg::csr_type        csr;
   pipd_pkg::req_item_type   push_item;
   pipd_pkg::queue_head_type head;
   pipd_pkg::rsp_item_type   rsp_item;
   logic                     pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= '0;
         ids_low_ff <= '0;
         ids_high_ff <= '0;
         priorities_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pipd_pkg::CSR_ENTRIES_IN_USE: begin
               entries_in_use_ff <= csr_wdata[pipd_pkg::COUNT_W-1:0];
            end
            pipd_pkg::CSR_IRQ_IDS_LOW: begin
               ids_low_ff <= csr_wdata;
            end
            pipd_pkg::CSR_IRQ_IDS_HIGH: begin
               ids_high_ff <= csr_wdata;
            end
            pipd_pkg::CSR_ENTRY_PRIORITIES: begin
               priorities_ff <= csr_wdata[pipd_pkg::PRIOS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr.entries_in_use = entries_in_use_ff;
   assign csr.irq_ids = {ids_high_ff, ids_low_ff};
   assign csr.priorities = priorities_ff;

   assign push_item.opcode = req_tuser;
   assign push_item.irq_number = req_tdata[pipd_pkg::NUMBER_W-1:0];
   assign push_item.argument = req_tdata[pipd_pkg::NUMBER_W +: pipd_pkg::ARG_W];

   pipd_queue #(
      .DEPTH(pipd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (push_item),
      .ready     (req_tready),
      .pop       (pop),
      .head      (head)
   );

   pipd_back #(
      .ENTRIES         (ENTRIES),
      .PRIORITY_LEVELS (PRIORITY_LEVELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {6'b0, rsp_item.saved_argument, rsp_item.entry_priority,
                       rsp_item.entry_index, rsp_item.status};
   assign rsp_tuser = rsp_item.reply_kind;
   assign rsp_tlast = rsp_item.last_result;

endmodule

[test/pending_irq_priority_dispatcher_test.sv]
module pending_irq_priority_dispatcher_test;
   import pipd_pkg::*;

   localparam int MAX_ENTRIES = ENTRIES_DEFAULT;
   localparam int LEVELS = LEVELS_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 34;

   // Directed table: entries 2 and 3 share a number, entries 2/4 and 0/6 share
   // a priority level.
   localparam logic [127:0] DIRECTED_IDS = {64'hA5A5_7FFE_00FF_8001,
                                            64'h1234_1234_FFFF_0000};
   localparam logic [31:0] DIRECTED_PRIOS = 32'h1F73_030F;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // Shadow copy of the block's configuration and state.
   logic [COUNT_W-1:0]     shadow_used = '0;
   logic [IDS_W-1:0]       shadow_ids = '0;
   logic [PRIOS_W-1:0]     shadow_prios = '0;
   logic [MAX_ENTRIES-1:0] shadow_pending = '0;
   logic [ARG_W-1:0]       shadow_args [MAX_ENTRIES];

   rsp_item_type expected_replies[$];
   rsp_item_type got_reply;
   rsp_item_type want_reply;

   bit steady = 1'b0;
   int fails = 0;
   int idle_cycles = 0;
   int raises_sent = 0;
   int runs_sent = 0;
   int dispatches_seen = 0;
   int configs_written = 0;

   pending_irq_priority_dispatcher dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // irq_number, argument
      .req_tuser  (req_tuser),   // opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // status, entry_index, entry_priority, saved_argument
      .rsp_tuser  (rsp_tuser),   // reply_kind
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no progress for %0d cycles, %0d replies outstanding", $time,
               STALL_LIMIT, expected_replies.size());
      $display("pending_irq_priority_dispatcher_test NOT OK");
      $finish;
   end

   // Works out the replies to one accepted item and updates the shadow state.
   function automatic void predict_replies(input logic op, input logic [NUMBER_W-1:0] num,
                                           input logic [ARG_W-1:0] arg);
      rsp_item_type     r;
      int               n;
      int               p;
      int               last_p;
      bit               hit;
      bit               slot_full [LEVELS];
      logic [INDEX_W-1:0] slot_entry [LEVELS];

      n = (shadow_used > MAX_ENTRIES) ? MAX_ENTRIES : int'(shadow_used);
      r = '0;
      if (op == OP_RAISE) begin
         r.reply_kind = KIND_RAISE;
         r.status = STATUS_UNKNOWN;
         r.last_result = 1'b1;
         hit = 1'b0;
         for (int k = 0; k < n; k++) begin
            if (!hit && shadow_ids[16*k +: 16] == num) begin
               hit = 1'b1;
               r.entry_index = INDEX_W'(k);
               if (shadow_pending[k]) begin
                  r.status = STATUS_DROPPED;
               end else begin
                  shadow_pending[k] = 1'b1;
                  shadow_args[k] = arg;
                  r.status = STATUS_ACCEPTED;
               end
            end
         end
         expected_replies.push_back(r);
      end else begin
         for (int q = 0; q < LEVELS; q++) begin
            slot_full[q] = 1'b0;
            slot_entry[q] = '0;
         end
         last_p = -1;
         // A later entry at the same level overwrites the earlier one.
         for (int k = 0; k < n; k++) begin
            if (shadow_pending[k]) begin
               p = int'(shadow_prios[4*k +: 4]);
               if (p >= LEVELS) p = LEVELS - 1;
               slot_full[p] = 1'b1;
               slot_entry[p] = INDEX_W'(k);
               if (p > last_p) last_p = p;
            end
         end
         shadow_pending = '0;
         r.reply_kind = KIND_RUN;
         if (last_p < 0) begin
            r.status = STATUS_NONE;
            r.last_result = 1'b1;
            expected_replies.push_back(r);
         end else begin
            for (int q = 0; q < LEVELS; q++) begin
               if (slot_full[q]) begin
                  r.status = STATUS_DISPATCHED;
                  r.entry_index = slot_entry[q];
                  r.entry_priority = PRIO_W'(q);
                  r.saved_argument = shadow_args[slot_entry[q]];
                  r.last_result = (q == last_p);
                  expected_replies.push_back(r);
               end
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_reply.reply_kind = rsp_tuser;
         got_reply.status = status_type'(rsp_tdata[2:0]);
         got_reply.entry_index = rsp_tdata[5:3];
         got_reply.entry_priority = rsp_tdata[9:6];
         got_reply.saved_argument = rsp_tdata[41:10];
         got_reply.last_result = rsp_tlast;
         if (got_reply.status == STATUS_DISPATCHED) dispatches_seen++;
         if (expected_replies.size() == 0) begin
            fails++;
            $display("%0t: unexpected reply: expected none, got kind %0d status %0d index %0d",
                     $time, got_reply.reply_kind, got_reply.status, got_reply.entry_index);
         end else begin
            want_reply = expected_replies.pop_front();
            if (got_reply.reply_kind !== want_reply.reply_kind ||
                got_reply.status !== want_reply.status ||
                got_reply.entry_index !== want_reply.entry_index ||
                got_reply.entry_priority !== want_reply.entry_priority ||
                got_reply.saved_argument !== want_reply.saved_argument ||
                got_reply.last_result !== want_reply.last_result) begin
               fails++;
               $display("%0t: reply mismatch: expected kind %0d status %0d index %0d prio %0d",
                        $time, want_reply.reply_kind, want_reply.status,
                        want_reply.entry_index, want_reply.entry_priority);
               $display("   arg %h last %0d; actual kind %0d status %0d index %0d prio %0d",
                        want_reply.saved_argument, want_reply.last_result,
                        got_reply.reply_kind, got_reply.status, got_reply.entry_index,
                        got_reply.entry_priority);
               $display("   arg %h last %0d", got_reply.saved_argument,
                        got_reply.last_result);
            end
         end
      end
   end

   // Called right after a rising edge; leaves req_tvalid high for the caller.
   task automatic send_item(input logic op, input logic [NUMBER_W-1:0] num,
                            input logic [ARG_W-1:0] arg);
      if (!steady && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {arg, num};
      do @(posedge clock); while (!req_tready);
      predict_replies(op, num, arg);
      if (op == OP_RAISE) raises_sent++;
      else runs_sent++;
   endtask

   task automatic raise_irq(input logic [NUMBER_W-1:0] num, input logic [ARG_W-1:0] arg);
      send_item(OP_RAISE, num, arg);
   endtask

   task automatic run_dispatch();
      send_item(OP_RUN, NUMBER_W'($urandom()), ARG_W'($urandom()));
   endtask

   // Waits until every expected reply has come back and the block is idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [COUNT_W-1:0] used, input logic [IDS_W-1:0] ids,
                            input logic [PRIOS_W-1:0] prios);
      csr_we <= 1'b1;
      csr_index <= CSR_ENTRIES_IN_USE;
      csr_wdata <= CSR_DATA_W'(used);
      @(posedge clock);
      csr_index <= CSR_IRQ_IDS_LOW;
      csr_wdata <= ids[63:0];
      @(posedge clock);
      csr_index <= CSR_IRQ_IDS_HIGH;
      csr_wdata <= ids[127:64];
      @(posedge clock);
      csr_index <= CSR_ENTRY_PRIORITIES;
      csr_wdata <= CSR_DATA_W'(prios);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      shadow_used = used;
      shadow_ids = ids;
      shadow_prios = prios;
      configs_written++;
   endtask

   // With no entries in use every raise is unknown and a run finds nothing.
   task automatic test_after_reset();
      raise_irq(16'h0000, 32'h0000_0000);
      run_dispatch();
      drain();
   endtask

   task automatic test_table_lookup();
      configure(4'd8, DIRECTED_IDS, DIRECTED_PRIOS);
      raise_irq(16'h0000, 32'h0000_0000);
      raise_irq(16'hFFFF, 32'hFFFF_FFFF);
      raise_irq(16'h1234, 32'h5555_AAAA);
      raise_irq(16'h1234, 32'h0F0F_F0F0);
      raise_irq(16'h8001, 32'hAAAA_5555);
      raise_irq(16'h00FF, 32'h1357_9BDF);
      raise_irq(16'h7FFE, 32'h8000_0001);
      raise_irq(16'hA5A5, 32'h7FFF_FFFE);
      raise_irq(16'h4321, 32'hDEAD_0000);
      run_dispatch();
      run_dispatch();
      drain();
   endtask

   // A count above the table size acts as a full table; entries outside the
   // count lose their pending marks on a run but are never dispatched.
   task automatic test_entry_limits();
      configure(4'd15, DIRECTED_IDS, DIRECTED_PRIOS);
      raise_irq(16'hA5A5, 32'h0000_0001);
      drain();
      configure(4'd3, DIRECTED_IDS, DIRECTED_PRIOS);
      run_dispatch();
      drain();
      configure(4'd8, DIRECTED_IDS, DIRECTED_PRIOS);
      run_dispatch();
      raise_irq(16'hA5A5, 32'h8000_0000);
      drain();
      configure(4'd4, DIRECTED_IDS, DIRECTED_PRIOS);
      raise_irq(16'h8001, 32'h0000_0002);
      run_dispatch();
      drain();
   endtask

   task automatic test_random_traffic();
      logic [COUNT_W-1:0] used;
      logic [IDS_W-1:0]   ids;
      logic [PRIOS_W-1:0] prios;

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0, 2, 5: used = 4'd8;
            3:       used = COUNT_W'($urandom_range(9, 15));
            default: used = COUNT_W'($urandom_range(1, 8));
         endcase
         for (int k = 0; k < MAX_ENTRIES; k++) begin
            if (k > 0 && $urandom_range(9) == 0) ids[16*k +: 16] = ids[16*(k-1) +: 16];
            else ids[16*k +: 16] = 16'($urandom());
         end
         // Narrow priority ranges force ties between pending entries.
         case (ph)
            1, 4: begin
               for (int k = 0; k < MAX_ENTRIES; k++) prios[4*k +: 4] = 4'($urandom_range(2));
            end
            2:       prios = '0;
            5:       prios = '1;
            default: prios = 32'($urandom());
         endcase
         configure(used, ids, prios);
         steady = (ph == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < 20) run_dispatch();
            else if ($urandom_range(99) < 75)
               raise_irq(shadow_ids[16*$urandom_range(MAX_ENTRIES-1) +: 16], 32'($urandom()));
            else raise_irq(16'($urandom()), 32'($urandom()));
         end
         drain();
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_table_lookup();
      test_entry_limits();
      test_random_traffic();
      $display("Sent %0d raises and %0d runs over %0d table settings;", raises_sent,
               runs_sent, configs_written);
      $display("checked %0d dispatch replies, %0d failures.", dispatches_seen, fails);
      if (fails == 0) begin
         $display("pending_irq_priority_dispatcher_test OK");
      end else begin
         $display("pending_irq_priority_dispatcher_test NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/pipd_pkg.sv
rtl/pipd_queue.sv
rtl/pipd_back.sv
rtl/pending_irq_priority_dispatcher.sv
test/pending_irq_priority_dispatcher_test.sv
